@@ src/tasd_pkg.sv @@
// Shared types, constants and helpers for the three-axis shake detector.
`timescale 1ns / 1ps
`default_nettype none
package tasd_pkg;

   localparam int SAMPLE_WIDTH = 16;
   localparam int ACC_W        = SAMPLE_WIDTH + 1;
   localparam int CMP_W        = (ACC_W > 17) ? ACC_W : 17;
   localparam int TIME_W       = 32;
   localparam int CSR_DATA_W   = 16;
   localparam int CSR_IDX_W    = 3;
   localparam int SEL_W        = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHECK_INTVL = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PEAK_HOLD   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIG_HOLD   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_SEL   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FORWARD_SEL = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_UP_SEL      = 3'd6;

   // axis select codes
   localparam logic [SEL_W-1:0] SEL_POS_X = 3'd0;
   localparam logic [SEL_W-1:0] SEL_NEG_X = 3'd1;
   localparam logic [SEL_W-1:0] SEL_POS_Y = 3'd2;
   localparam logic [SEL_W-1:0] SEL_NEG_Y = 3'd3;
   localparam logic [SEL_W-1:0] SEL_POS_Z = 3'd4;
   localparam logic [SEL_W-1:0] SEL_NEG_Z = 3'd5;

   typedef struct packed {
      logic [15:0]      threshold;
      logic [15:0]      sample_gap;
      logic [15:0]      peak_hold_time;
      logic [15:0]      trigger_holdoff;
      logic [SEL_W-1:0] right_sel;
      logic [SEL_W-1:0] forward_sel;
      logic [SEL_W-1:0] up_sel;
   } tasd_cfg_type;

   localparam tasd_cfg_type CFG_RESET = '{
      threshold:       16'd8000,
      sample_gap:      16'd20,
      peak_hold_time:  16'd300,
      trigger_holdoff: 16'd500,
      right_sel:       SEL_POS_X,
      forward_sel:     SEL_POS_Y,
      up_sel:          SEL_POS_Z
   };

   typedef struct packed {
      logic pos;
      logic neg;
   } tasd_evt_type;

   // signed axis remap; unused codes read as zero
   function automatic logic signed [ACC_W-1:0] pick_axis(
      input logic [SEL_W-1:0]               sel,
      input logic signed [SAMPLE_WIDTH-1:0] ax,
      input logic signed [SAMPLE_WIDTH-1:0] ay,
      input logic signed [SAMPLE_WIDTH-1:0] az
   );
      logic signed [ACC_W-1:0] x_ext;
      logic signed [ACC_W-1:0] y_ext;
      logic signed [ACC_W-1:0] z_ext;
      logic signed [ACC_W-1:0] res;
      x_ext = ACC_W'(ax);
      y_ext = ACC_W'(ay);
      z_ext = ACC_W'(az);
      case (sel)
         SEL_POS_X: res = x_ext;
         SEL_NEG_X: res = -x_ext;
         SEL_POS_Y: res = y_ext;
         SEL_NEG_Y: res = -y_ext;
         SEL_POS_Z: res = z_ext;
         SEL_NEG_Z: res = -z_ext;
         default:   res = '0;
      endcase
      return res;
   endfunction

endpackage
`default_nettype wire

@@ src/tasd_req_if.sv @@
// Request channel: timestamped three-axis sample.
`timescale 1ns / 1ps
`default_nettype none
interface tasd_req_if import tasd_pkg::*; ();
   logic                           valid;
   logic                           ready;
   logic [TIME_W-1:0]              time_ms;
   logic signed [SAMPLE_WIDTH-1:0] accel_x;
   logic signed [SAMPLE_WIDTH-1:0] accel_y;
   logic signed [SAMPLE_WIDTH-1:0] accel_z;

   modport source (output valid, time_ms, accel_x, accel_y, accel_z, input ready);
   modport sink   (input valid, time_ms, accel_x, accel_y, accel_z, output ready);
endinterface
`default_nettype wire

@@ src/tasd_rsp_if.sv @@
// Response channel: gate flag and directional shake events.
`timescale 1ns / 1ps
`default_nettype none
interface tasd_rsp_if import tasd_pkg::*; ();
   logic valid;
   logic ready;
   logic sample_taken;
   logic shake_right;
   logic shake_left;
   logic shake_forward;
   logic shake_back;
   logic shake_up;
   logic shake_down;

   modport source (output valid, sample_taken, shake_right, shake_left, shake_forward,
                   shake_back, shake_up, shake_down, input ready);
   modport sink   (input valid, sample_taken, shake_right, shake_left, shake_forward,
                   shake_back, shake_up, shake_down, output ready);
endinterface
`default_nettype wire

@@ src/three_axis_shake_detector_unit.sv @@
// A request enters the input register, then the response register once free.
// Throughput: one request per cycle unless rsp ready stalls; each register
//   holds one entry, so a request is taken while a finished response waits.
// Per-request work (interval gate, remap, three axis units) sits between them.
// Reset (synchronous, active high) empties both stages, restores register
//   defaults and zeroes the sample time, peaks, peak times and event times.
`timescale 1ns / 1ps
`default_nettype none
module three_axis_shake_detector_unit import tasd_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   tasd_req_if.sink                   req_bus,
   tasd_rsp_if.source                 rsp_bus,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   tasd_cfg_type cfg;

   tasd_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // ---- input register --------------------------------------------------
   logic                           in_valid_ff, in_valid_in;
   logic [TIME_W-1:0]              in_time_ff;
   logic signed [SAMPLE_WIDTH-1:0] in_ax_ff, in_ay_ff, in_az_ff;

   // ---- response register -----------------------------------------------
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_taken_ff;
   logic [5:0] rsp_shake_ff;

   logic [TIME_W-1:0] last_sample_ff, last_sample_in;

   logic req_fire;
   logic out_free;   // response register can take a new result
   logic advance;    // input register moves into the response register
   logic gate_pass;  // far enough from the last taken sample
   logic step;       // state update for a taken sample

   logic signed [ACC_W-1:0] acc_right, acc_forward, acc_up;
   tasd_evt_type            evt_right, evt_forward, evt_up;

   assign out_free        = !rsp_valid_ff || rsp_bus.ready;
   assign advance         = in_valid_ff && out_free;
   assign req_bus.ready   = !in_valid_ff || out_free;
   assign req_fire        = req_bus.valid && req_bus.ready;

   assign gate_pass = (in_time_ff - last_sample_ff) >= TIME_W'(cfg.sample_gap);
   assign step      = advance && gate_pass;

   assign acc_right   = pick_axis(cfg.right_sel,   in_ax_ff, in_ay_ff, in_az_ff);
   assign acc_forward = pick_axis(cfg.forward_sel, in_ax_ff, in_ay_ff, in_az_ff);
   assign acc_up      = pick_axis(cfg.up_sel,      in_ax_ff, in_ay_ff, in_az_ff);

   tasd_axis u_axis_right (
      .clock   (clock),
      .reset   (reset),
      .enable  (step),
      .time_ms (in_time_ff),
      .acc     (acc_right),
      .cfg     (cfg),
      .evt     (evt_right)
   );

   tasd_axis u_axis_forward (
      .clock   (clock),
      .reset   (reset),
      .enable  (step),
      .time_ms (in_time_ff),
      .acc     (acc_forward),
      .cfg     (cfg),
      .evt     (evt_forward)
   );

   tasd_axis u_axis_up (
      .clock   (clock),
      .reset   (reset),
      .enable  (step),
      .time_ms (in_time_ff),
      .acc     (acc_up),
      .cfg     (cfg),
      .evt     (evt_up)
   );

   always_comb begin
      in_valid_in    = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      rsp_valid_in   = advance ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);
      last_sample_in = step ? in_time_ff : last_sample_ff;
   end

   // control and detector state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         last_sample_ff <= '0;
      end else begin
         in_valid_ff    <= in_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         last_sample_ff <= last_sample_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_time_ff <= req_bus.time_ms;
         in_ax_ff   <= req_bus.accel_x;
         in_ay_ff   <= req_bus.accel_y;
         in_az_ff   <= req_bus.accel_z;
      end
      if (advance) begin
         rsp_taken_ff <= gate_pass;
         rsp_shake_ff <= {evt_right.pos, evt_right.neg, evt_forward.pos,
                          evt_forward.neg, evt_up.pos, evt_up.neg};
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.sample_taken  = rsp_taken_ff;
   assign rsp_bus.shake_right   = rsp_shake_ff[5];
   assign rsp_bus.shake_left    = rsp_shake_ff[4];
   assign rsp_bus.shake_forward = rsp_shake_ff[3];
   assign rsp_bus.shake_back    = rsp_shake_ff[2];
   assign rsp_bus.shake_up      = rsp_shake_ff[1];
   assign rsp_bus.shake_down    = rsp_shake_ff[0];

`ifndef ASSERT_OFF
   // a gated sample never reports an event
   a_gated_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_taken_ff |-> rsp_shake_ff == '0)
      else $error("event on gated sample");

   // at most one direction per axis
   a_one_dir: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_shake_ff[5] && rsp_shake_ff[4]) &&
                       !(rsp_shake_ff[3] && rsp_shake_ff[2]) &&
                       !(rsp_shake_ff[1] && rsp_shake_ff[0]))
      else $error("both directions on one axis");

   // a gated sample leaves the last sample time alone
   a_gate_holds: assert property (@(posedge clock) disable iff (reset)
      advance && !gate_pass |=> $stable(last_sample_ff))
      else $error("last sample time moved on gated sample");

   // both stages come out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !in_valid_ff && !rsp_valid_ff)
      else $error("stage valid after reset");
`endif

endmodule
`default_nettype wire

@@ src/tasd_cfg.sv @@
// Configuration register file.
`timescale 1ns / 1ps
`default_nettype none
module tasd_cfg import tasd_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output tasd_cfg_type               cfg
);

   tasd_cfg_type cfg_ff;
   tasd_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_THRESHOLD:   cfg_in.threshold       = csr_wdata;
            CSR_CHECK_INTVL: cfg_in.sample_gap      = csr_wdata;
            CSR_PEAK_HOLD:   cfg_in.peak_hold_time  = csr_wdata;
            CSR_TRIG_HOLD:   cfg_in.trigger_holdoff = csr_wdata;
            CSR_RIGHT_SEL:   cfg_in.right_sel       = csr_wdata[SEL_W-1:0];
            CSR_FORWARD_SEL: cfg_in.forward_sel     = csr_wdata[SEL_W-1:0];
            CSR_UP_SEL:      cfg_in.up_sel          = csr_wdata[SEL_W-1:0];
            default: ;  // unmapped index, dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

@@ src/tasd_axis.sv @@
// Per-axis peak tracking and swing detection.
`timescale 1ns / 1ps
`default_nettype none
module tasd_axis import tasd_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    enable,
   input  wire logic [TIME_W-1:0]       time_ms,
   input  wire logic signed [ACC_W-1:0] acc,
   input  wire tasd_cfg_type            cfg,
   output tasd_evt_type                 evt
);

   logic signed [ACC_W-1:0] peak_value_ff, peak_value_in;
   logic [TIME_W-1:0]       peak_time_ff, peak_time_in;
   logic [TIME_W-1:0]       last_event_ff, last_event_in;

   logic [ACC_W-1:0]  mag;
   logic [TIME_W-1:0] peak_age;
   logic [TIME_W-1:0] event_age;
   logic              qualify;
   logic              stale;
   logic              acc_pos, acc_neg, peak_pos, peak_neg;
   logic              same_sign;
   logic              refresh;
   logic              fire;

   always_comb begin
      mag       = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
      qualify   = CMP_W'(mag) >= CMP_W'(cfg.threshold);
      peak_age  = time_ms - peak_time_ff;
      event_age = time_ms - last_event_ff;
      stale     = peak_age > TIME_W'(cfg.peak_hold_time);
      acc_neg   = acc[ACC_W-1];
      acc_pos   = !acc[ACC_W-1] && (acc != '0);
      peak_neg  = peak_value_ff[ACC_W-1];
      peak_pos  = !peak_value_ff[ACC_W-1] && (peak_value_ff != '0);
      same_sign = (acc_pos == peak_pos) && (acc_neg == peak_neg);
      refresh   = enable && qualify && (stale || same_sign);
      // swing against an opposite peak, outside the hold-off window
      fire      = enable && qualify && !(stale || same_sign) &&
                  (event_age >= TIME_W'(cfg.trigger_holdoff));

      peak_value_in = refresh ? acc : peak_value_ff;
      peak_time_in  = refresh ? time_ms : peak_time_ff;
      last_event_in = fire ? time_ms : last_event_ff;

      evt.pos = fire && peak_pos;
      evt.neg = fire && !peak_pos;  // zero peak counts as negative-first
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_value_ff <= '0;
         peak_time_ff  <= '0;
         last_event_ff <= '0;
      end else begin
         peak_value_ff <= peak_value_in;
         peak_time_ff  <= peak_time_in;
         last_event_ff <= last_event_in;
      end
   end

endmodule
`default_nettype wire

@@ dv/tasd_shake_checker.sv @@
// Shake detector checker: predicts each response from accepted requests and compares.
`timescale 1ns / 1ps
module tasd_shake_checker import tasd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   tasd_req_if                   req_mon,
   tasd_rsp_if                   rsp_mon,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending
);

   // bit order: taken is the MSB, down the LSB
   typedef struct packed {
      logic taken;
      logic right;
      logic left;
      logic fwd;
      logic back;
      logic up;
      logic down;
   } shake_flags_t;

   string flag_name [7] = '{"shake_down", "shake_up", "shake_back", "shake_forward",
                            "shake_left", "shake_right", "sample_taken"};

   tasd_cfg_type            cfg;
   logic [TIME_W-1:0]       last_taken_ms;
   logic signed [ACC_W-1:0] peak_acc [3];
   logic [TIME_W-1:0]       peak_ms [3];
   logic [TIME_W-1:0]       event_ms [3];
   shake_flags_t            expected_flags [$];
   int                      fail_tally = 0;

   function automatic logic signed [ACC_W-1:0] remap_axis(
      input logic [SEL_W-1:0]      sel,
      input logic signed [ACC_W-1:0] xs,
      input logic signed [ACC_W-1:0] ys,
      input logic signed [ACC_W-1:0] zs
   );
      case (sel)
         SEL_POS_X: return xs;
         SEL_NEG_X: return -xs;
         SEL_POS_Y: return ys;
         SEL_NEG_Y: return -ys;
         SEL_POS_Z: return zs;
         SEL_NEG_Z: return -zs;
         default:   return '0;
      endcase
   endfunction

   function automatic int sign3(input logic signed [ACC_W-1:0] v);
      if (v > 0) return 1;
      if (v < 0) return -1;
      return 0;
   endfunction

   function automatic shake_flags_t predict_shake(
      input logic [TIME_W-1:0]              t,
      input logic signed [SAMPLE_WIDTH-1:0] ax,
      input logic signed [SAMPLE_WIDTH-1:0] ay,
      input logic signed [SAMPLE_WIDTH-1:0] az
   );
      shake_flags_t            f;
      tasd_evt_type            ev [3];
      logic signed [ACC_W-1:0] acc [3];
      logic [ACC_W-1:0]        mag;
      logic [TIME_W-1:0]       gap;
      f = '0;
      for (int i = 0; i < 3; i++) ev[i] = '0;
      gap = t - last_taken_ms;
      if (gap < TIME_W'(cfg.sample_gap)) return f;
      last_taken_ms = t;
      f.taken = 1'b1;
      acc[0] = remap_axis(cfg.right_sel, ax, ay, az);
      acc[1] = remap_axis(cfg.forward_sel, ax, ay, az);
      acc[2] = remap_axis(cfg.up_sel, ax, ay, az);
      for (int i = 0; i < 3; i++) begin
         mag = acc[i][ACC_W-1] ? ACC_W'(-acc[i]) : ACC_W'(acc[i]);
         if (CMP_W'(mag) < CMP_W'(cfg.threshold)) continue;
         gap = t - peak_ms[i];
         if (gap > TIME_W'(cfg.peak_hold_time) || sign3(acc[i]) == sign3(peak_acc[i])) begin
            peak_ms[i]  = t;
            peak_acc[i] = acc[i];
         end else begin
            gap = t - event_ms[i];
            if (gap < TIME_W'(cfg.trigger_holdoff)) continue;
            event_ms[i] = t;
            // zero stored peak counts as negative-first
            if (peak_acc[i] > 0) ev[i].pos = 1'b1;
            else                 ev[i].neg = 1'b1;
         end
      end
      f.right = ev[0].pos;
      f.left  = ev[0].neg;
      f.fwd   = ev[1].pos;
      f.back  = ev[1].neg;
      f.up    = ev[2].pos;
      f.down  = ev[2].neg;
      return f;
   endfunction

   always @(posedge clock) begin : watch
      shake_flags_t want;
      shake_flags_t got;
      if (reset) begin
         cfg           = CFG_RESET;
         last_taken_ms = '0;
         for (int i = 0; i < 3; i++) begin
            peak_acc[i] = '0;
            peak_ms[i]  = '0;
            event_ms[i] = '0;
         end
         expected_flags.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_THRESHOLD:   cfg.threshold       = csr_wdata;
               CSR_CHECK_INTVL: cfg.sample_gap      = csr_wdata;
               CSR_PEAK_HOLD:   cfg.peak_hold_time  = csr_wdata;
               CSR_TRIG_HOLD:   cfg.trigger_holdoff = csr_wdata;
               CSR_RIGHT_SEL:   cfg.right_sel       = csr_wdata[SEL_W-1:0];
               CSR_FORWARD_SEL: cfg.forward_sel     = csr_wdata[SEL_W-1:0];
               CSR_UP_SEL:      cfg.up_sel          = csr_wdata[SEL_W-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready)
            expected_flags.push_back(predict_shake(req_mon.time_ms, req_mon.accel_x,
                                                   req_mon.accel_y, req_mon.accel_z));
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.sample_taken, rsp_mon.shake_right, rsp_mon.shake_left,
                    rsp_mon.shake_forward, rsp_mon.shake_back, rsp_mon.shake_up,
                    rsp_mon.shake_down};
            if (expected_flags.size() == 0) begin
               fail_tally++;
               $display("%0t: unexpected response, expected none, actual %b", $time, got);
            end else begin
               want = expected_flags.pop_front();
               for (int i = 6; i >= 0; i--) begin
                  if (want[i] !== got[i]) begin
                     fail_tally++;
                     $display("%0t: %s mismatch, expected %b, actual %b",
                              $time, flag_name[i], want[i], got[i]);
                  end
               end
            end
         end
      end
      fail_count <= fail_tally;
      pending    <= expected_flags.size();
   end

endmodule

@@ dv/tb_three_axis_shake_detector_unit.sv @@
// Testbench top for the shake detector: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps
module tb_three_axis_shake_detector_unit;
   import tasd_pkg::*;

   localparam int HALF_PERIOD     = 6;
   localparam int RESET_CYCLES    = 4;
   localparam int QUIET_LIMIT     = 2000;  // cycles with no handshake before giving up
   localparam int SETTLE_CYCLES   = 3;     // idle wait after the last response is back
   localparam int RANDOM_PHASES   = 8;
   localparam int PHASE_REQUESTS  = 85;
   localparam int LONG_HOLD       = 64;
   localparam int HOLD_AT         = 20;    // request number where the receiver freezes
   localparam int DRAIN_AT        = 50;    // request number where the sender waits dry

   // select codes the remap treats as "no source"
   localparam logic [SEL_W-1:0]     SEL_NONE_LO  = 3'd6;
   localparam logic [SEL_W-1:0]     SEL_NONE_HI  = 3'd7;
   // index past the register file, must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 3'd7;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int                    send_idle_pct = 0;
   int                    stall_pct = 0;
   int                    long_hold_cycles = 0;
   int                    quiet_cycles = 0;
   int                    fail_count;
   int                    pending;
   tasd_cfg_type          cur_cfg;
   logic [TIME_W-1:0]     sensor_ms;

   tasd_req_if req_ch ();
   tasd_rsp_if rsp_ch ();

   three_axis_shake_detector_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_ch),
      .rsp_bus   (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   tasd_shake_checker shake_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Receiver: random back-pressure, plus one long freeze per phase while the
   // sender keeps offering, so both stages fill and req ready drops.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (long_hold_cycles) @(posedge clock);
            long_hold_cycles = 0;
         end
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Watchdog: any handshake on either side counts as progress.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one sample; returns on the edge that takes it, valid still high.
   task automatic offer_sample(input logic [TIME_W-1:0] t,
                               input logic signed [SAMPLE_WIDTH-1:0] x,
                               input logic signed [SAMPLE_WIDTH-1:0] y,
                               input logic signed [SAMPLE_WIDTH-1:0] z);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.time_ms <= t;
      req_ch.accel_x <= x;
      req_ch.accel_y <= y;
      req_ch.accel_z <= z;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // Drop valid and wait until every predicted response has come back.
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_put(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Writes the whole register set; optionally one stray write past the map.
   task automatic load_config(input tasd_cfg_type c, input logic stray);
      csr_put(CSR_THRESHOLD,   c.threshold);
      csr_put(CSR_CHECK_INTVL, c.sample_gap);
      csr_put(CSR_PEAK_HOLD,   c.peak_hold_time);
      csr_put(CSR_TRIG_HOLD,   c.trigger_holdoff);
      csr_put(CSR_RIGHT_SEL,   CSR_DATA_W'(c.right_sel));
      csr_put(CSR_FORWARD_SEL, CSR_DATA_W'(c.forward_sel));
      csr_put(CSR_UP_SEL,      CSR_DATA_W'(c.up_sel));
      if (stray) csr_put(CSR_UNMAPPED, '1);
      csr_wr_en <= 1'b0;
      cur_cfg = c;
   endtask

   function automatic tasd_cfg_type phase_config(input int ph);
      tasd_cfg_type c;
      case (ph)
         0: c = CFG_RESET;
         1: c = '{threshold: 16'd0, sample_gap: 16'd0, peak_hold_time: 16'd0,
                  trigger_holdoff: 16'd0, right_sel: SEL_NEG_X, forward_sel: SEL_NEG_Y,
                  up_sel: SEL_NEG_Z};
         2: c = '{threshold: 16'd32768, sample_gap: 16'hFFFF, peak_hold_time: 16'hFFFF,
                  trigger_holdoff: 16'hFFFF, right_sel: SEL_NONE_LO, forward_sel: SEL_NONE_HI,
                  up_sel: SEL_POS_X};
         3: c = '{threshold: 16'd16000, sample_gap: 16'd5, peak_hold_time: 16'd200,
                  trigger_holdoff: 16'd100, right_sel: SEL_POS_Y, forward_sel: SEL_POS_Z,
                  up_sel: SEL_NEG_X};
         default: begin
            c.threshold       = ($urandom_range(4) == 0) ? 16'd0 : 16'($urandom_range(32768, 500));
            c.sample_gap      = 16'($urandom_range(100));
            c.peak_hold_time  = 16'($urandom_range(2000, 1));
            c.trigger_holdoff = 16'($urandom_range(800));
            c.right_sel       = SEL_W'($urandom_range(7));
            c.forward_sel     = SEL_W'($urandom_range(7));
            c.up_sel          = SEL_W'($urandom_range(7));
         end
      endcase
      return c;
   endfunction

   // Mostly readings past the threshold with a random sign, so that swings
   // (opposite sign inside the hold window) happen often on every axis.
   function automatic logic signed [SAMPLE_WIDTH-1:0] pick_reading();
      int k;
      int thr;
      int v;
      k   = $urandom_range(99);
      thr = int'(cur_cfg.threshold);
      if (k < 35)      v = -int'($urandom_range(32768, thr));
      else if (k < 65) v = int'($urandom_range(32767, (thr > 32767) ? 32767 : thr));
      else if (k < 80) begin
         v = (thr == 0) ? 0 : int'($urandom_range(thr - 1));
         if ($urandom_range(1)) v = -v;
      end else if (k < 92) begin
         case ($urandom_range(5))
            0:       v = -32768;
            1:       v = 32767;
            2:       v = 0;
            3:       v = (thr > 32767) ? 32767 : thr;
            4:       v = -thr;
            default: v = (thr == 0) ? 0 : thr - 1;
         endcase
      end else v = int'($urandom());
      return SAMPLE_WIDTH'(v);
   endfunction

   // Time steps are shaped from the current registers: gated, inside the hold
   // window, just stale, exactly on the interval, or anywhere (wrap).
   task automatic offer_random_sample();
      int                kind;
      logic [TIME_W-1:0] ci;
      logic [TIME_W-1:0] hold;
      logic [TIME_W-1:0] step;
      ci   = TIME_W'(cur_cfg.sample_gap);
      hold = TIME_W'(cur_cfg.peak_hold_time);
      kind = $urandom_range(99);
      if (kind < 15)      step = (ci == 0) ? '0 : TIME_W'($urandom_range(ci - 1));
      else if (kind < 70) step = ci + TIME_W'($urandom_range(hold));
      else if (kind < 85) step = ci + hold + 1 + TIME_W'($urandom_range(cur_cfg.trigger_holdoff));
      else if (kind < 95) step = ci;
      else                step = $urandom();
      sensor_ms = sensor_ms + step;
      offer_sample(sensor_ms, pick_reading(), pick_reading(), pick_reading());
   endtask

   task automatic run_directed();
      tasd_cfg_type c;
      // reset registers: thr 8000, interval 20, hold 300, holdoff 500, x/y/z
      offer_sample(32'd5,    16'sd9000,   16'sd0,      16'sd0);       // gated right after reset
      offer_sample(32'd20,   16'sd10000,  16'sd0,      16'sd0);       // swing on zero peak, held off
      offer_sample(32'd30,   16'sd0,      16'sd0,      16'sd0);       // inside interval
      offer_sample(32'd100,  -16'sd10000, 16'sd0,      16'sd0);       // swing held off
      offer_sample(32'd600,  -16'sd9000,  16'sd0,      16'sd0);       // stale peak replaced
      offer_sample(32'd700,  16'sd9000,   -16'sd12000, 16'sd0);       // left fires
      offer_sample(32'd800,  -16'sd9000,  16'sd12000,  16'sd32767);   // back fires
      offer_sample(32'd1100, 16'sd0,      16'sd0,      -16'sd32768);  // hold edge: not stale
      offer_sample(32'd1401, 16'sd7999,   16'sd0,      16'sd8000);    // exact threshold
      offer_sample(32'd1421, 16'sd0,      -16'sd32768, -16'sd8000);
      offer_sample(32'hFFFF_FFF0, 16'sd32767, 16'sd32767, -16'sd32768);
      offer_sample(32'h0000_0004, -16'sd32768, -16'sd1, 16'sd32767);  // wrapped gap
      offer_sample(32'h0000_0017, -16'sd1, -16'sd1, -16'sd1);         // wrapped, gated
      settle();
      // zero threshold, zero windows, negated x and the two dead selects
      c = '{threshold: 16'd0, sample_gap: 16'd0, peak_hold_time: 16'd0,
            trigger_holdoff: 16'd0, right_sel: SEL_NEG_X, forward_sel: SEL_NONE_LO,
            up_sel: SEL_NONE_HI};
      load_config(c, 1'b1);
      offer_sample(32'h100, -16'sd32768, 16'sd5,   -16'sd5);  // negated minimum
      offer_sample(32'h100, 16'sd0,      16'sd0,   16'sd0);   // zero reading completes swing
      offer_sample(32'h100, 16'sd100,    16'sd0,   16'sd0);
      offer_sample(32'h101, 16'sd32767,  -16'sd1,  16'sd1);
      sensor_ms = 32'h101;
   endtask

   initial begin : stimulus
      reset          <= 1'b1;
      csr_wr_en      <= 1'b0;
      csr_index      <= '0;
      csr_wdata      <= '0;
      req_ch.valid   <= 1'b0;
      req_ch.time_ms <= '0;
      req_ch.accel_x <= '0;
      req_ch.accel_y <= '0;
      req_ch.accel_z <= '0;
      cur_cfg   = CFG_RESET;
      sensor_ms = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      run_directed();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         settle();
         load_config(phase_config(ph), 1'b0);
         // pacing: none, sender gaps, receiver stalls, both
         case (ph % 4)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 50; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 50; end
            default: begin send_idle_pct = 23; stall_pct = 23; end
         endcase
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            if (n == HOLD_AT) long_hold_cycles = LONG_HOLD;
            if (n == DRAIN_AT) settle();
            offer_random_sample();
         end
      end

      settle();
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
